[rtl/ute_pkg.sv]
// shared types, constants and tables for the utc date to epoch seconds block
// no dependencies; used by the encode and decode pipes and the top level
`default_nettype none

package ute_pkg;

  // accepted range of years since 1900, before and after the month carry
  localparam int YEAR_MIN = 69;
  localparam int YEAR_MAX = 139;
  localparam int EPOCH_YEAR = 70;
  localparam int LEAP_BIAS = 17;
  localparam int DAYS_PER_YEAR = 365;

  // days from 1968-01-01 (start of a leap cycle) to 1970-01-01
  localparam int EPOCH_CYCLE_OFS = 731;
  localparam int DAYS_PER_CYCLE = 1461;
  localparam int CYCLE_BASE_YEAR = 68;

  // reciprocals for exact division by constants over the ranges in use
  localparam logic [30:0] RECIP_DIV3 = 31'd715827883;   // 2^31 / 3, rounded up
  localparam logic [24:0] RECIP_DIV675 = 25'd25451659;  // 2^34 / 675, rounded up
  localparam logic [16:0] RECIP_DIV3600 = 17'd74566;    // 2^28 / 3600, rounded up
  localparam logic [14:0] RECIP_DIV1461 = 15'd22967;    // 2^25 / 1461, rounded up
  localparam logic [15:0] RECIP_DIV7 = 16'd37450;       // 2^18 / 7, rounded up
  localparam logic [12:0] RECIP_DIV60 = 13'd4370;       // 2^18 / 60, rounded up

  // encode pipe to decode pipe
  typedef struct packed {
    logic        vld;
    logic        err;
    logic [30:0] secs;
  } enc_out_t;

  // one result beat
  typedef struct packed {
    logic        vld;
    logic [30:0] epoch_seconds;
    logic        error_flag;
    logic [7:0]  norm_year;
    logic [3:0]  norm_month;
    logic [4:0]  norm_mday;
    logic [4:0]  norm_hour;
    logic [5:0]  norm_minute;
    logic [5:0]  norm_second;
    logic [2:0]  week_day;
    logic [8:0]  year_day;
  } dec_out_t;

  // cumulative days before each month, minus one
  function automatic logic signed [9:0] month_base(input logic [3:0] m);
    logic signed [9:0] b;
    case (m)
      4'd0:    b = -10'sd1;
      4'd1:    b = 10'sd30;
      4'd2:    b = 10'sd58;
      4'd3:    b = 10'sd89;
      4'd4:    b = 10'sd119;
      4'd5:    b = 10'sd150;
      4'd6:    b = 10'sd180;
      4'd7:    b = 10'sd211;
      4'd8:    b = 10'sd242;
      4'd9:    b = 10'sd272;
      4'd10:   b = 10'sd303;
      4'd11:   b = 10'sd333;
      default: b = 10'sd364;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

[rtl/ute_if.sv]
// valid/ready channel interfaces for input beats and result beats
// depends on nothing; the top level uses them as its ports
`default_nettype none

interface ute_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] year_since_1900;
  logic signed [31:0] month_raw;
  logic signed [31:0] day_of_month;
  logic signed [31:0] hour_raw;
  logic signed [31:0] minute_raw;
  logic signed [31:0] second_raw;

  modport source (output valid, year_since_1900, month_raw, day_of_month, hour_raw,
                  minute_raw, second_raw, input ready);
  modport sink (input valid, year_since_1900, month_raw, day_of_month, hour_raw,
                minute_raw, second_raw, output ready);
endinterface

interface ute_out_if;
  logic        valid;
  logic        ready;
  logic [30:0] epoch_seconds;
  logic        error_flag;
  logic [7:0]  norm_year;
  logic [3:0]  norm_month;
  logic [4:0]  norm_mday;
  logic [4:0]  norm_hour;
  logic [5:0]  norm_minute;
  logic [5:0]  norm_second;
  logic [2:0]  week_day;
  logic [8:0]  year_day;

  modport source (output valid, epoch_seconds, error_flag, norm_year, norm_month, norm_mday,
                  norm_hour, norm_minute, norm_second, week_day, year_day, input ready);
  modport sink (input valid, epoch_seconds, error_flag, norm_year, norm_month, norm_mday,
                norm_hour, norm_minute, norm_second, week_day, year_day, output ready);
endinterface

`default_nettype wire

[rtl/ute_encode.sv]
// six-stage pipe: year check, month carry, day count, then checked seconds chain
// depends on ute_pkg
`default_nettype none

module ute_encode import ute_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  logic               in_vld,
  input  logic signed [31:0] year_i,
  input  logic signed [31:0] mon_i,
  input  logic signed [31:0] mday_i,
  input  logic signed [31:0] hour_i,
  input  logic signed [31:0] min_i,
  input  logic signed [31:0] sec_i,
  output enc_out_t           res
);

  function automatic logic fits32(input logic signed [39:0] v);
    return (v[39:31] == '0) || (v[39:31] == '1);
  endfunction

  // t*24+a or t*60+a, with an overflow flag on top
  function automatic logic [32:0] mac(input logic signed [31:0] t, input logic by60,
                                      input logic signed [31:0] a);
    logic signed [39:0] p;
    logic signed [39:0] s;
    p = by60 ? ((40'(t) <<< 6) - (40'(t) <<< 2)) : ((40'(t) <<< 4) + (40'(t) <<< 3));
    s = p + 40'(a);
    return {!fits32(p) || !fits32(s), s[31:0]};
  endfunction

  logic [6:1] v_r, e_r;

  // stage 1
  logic [31:0] abs_mon;
  logic [60:0] qprod;
  logic        yr_ok;
  logic [7:0]  yr1_r;
  logic        neg1_r;
  logic [31:0] abs1_r;
  logic [27:0] q1_r;

  // stage 2
  logic [31:0]        r32;
  logic [3:0]         rem4;
  logic signed [29:0] qx, dlt, nyear;
  logic               yr2_ok;
  logic [3:0]         mon2;
  logic [7:0]         yr2_r;
  logic [3:0]         mon2_r;

  // stage 3
  logic signed [16:0] days;
  logic signed [32:0] t33;
  logic               leap;

  // seconds chain
  logic signed [31:0] t3_r, t4_r, t5_r, t6_r;
  logic [32:0]        m4, m5, m6;

  // passengers
  logic signed [31:0] mday1_r, mday2_r;
  logic signed [31:0] hour1_r, hour2_r, hour3_r;
  logic signed [31:0] min1_r, min2_r, min3_r, min4_r;
  logic signed [31:0] sec1_r, sec2_r, sec3_r, sec4_r, sec5_r;

  assign yr_ok = (year_i >= YEAR_MIN) && (year_i <= YEAR_MAX);
  assign abs_mon = mon_i[31] ? 32'(-mon_i) : 32'(mon_i);
  assign qprod = 61'(abs_mon[31:2]) * 61'(RECIP_DIV3);

  assign r32 = abs1_r - 32'({q1_r, 3'b000}) - 32'({q1_r, 2'b00});
  assign rem4 = r32[3:0];
  assign qx = $signed({2'b00, q1_r});
  assign dlt = neg1_r ? -(qx + $signed({29'd0, rem4 != 4'd0})) : qx;
  assign nyear = $signed({22'd0, yr1_r}) + dlt;
  assign yr2_ok = (nyear >= YEAR_MIN) && (nyear <= YEAR_MAX);
  assign mon2 = !neg1_r ? rem4 : ((rem4 == 4'd0) ? 4'd0 : 4'd12 - rem4);

  assign leap = (yr2_r[1:0] == 2'b00) && (mon2_r > 4'd1);
  assign days = 17'(month_base(mon2_r)) + $signed({16'd0, leap})
              + 17'(($signed({9'd0, yr2_r}) - 17'(EPOCH_YEAR)) * 17'(DAYS_PER_YEAR))
              + $signed({2'b00, 15'((yr2_r - 8'd1) >> 2)}) - 17'(LEAP_BIAS);
  assign t33 = 33'(days) + 33'(mday2_r);

  assign m4 = mac(t3_r, 1'b0, hour3_r);
  assign m5 = mac(t4_r, 1'b1, min4_r);
  assign m6 = mac(t5_r, 1'b1, sec5_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[5:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r[1] <= !yr_ok;
      e_r[2] <= e_r[1] || !yr2_ok;
      e_r[3] <= e_r[2] || (t33[32] != t33[31]);
      e_r[4] <= e_r[3] || m4[32];
      e_r[5] <= e_r[4] || m5[32];
      e_r[6] <= e_r[5] || m6[32] || m6[31];
      yr1_r <= year_i[7:0];
      neg1_r <= mon_i[31];
      abs1_r <= abs_mon;
      q1_r <= qprod[58:31];
      yr2_r <= nyear[7:0];
      mon2_r <= mon2;
      t3_r <= t33[31:0];
      t4_r <= m4[31:0];
      t5_r <= m5[31:0];
      t6_r <= m6[31:0];
      mday1_r <= mday_i;
      mday2_r <= mday1_r;
      hour1_r <= hour_i;
      hour2_r <= hour1_r;
      hour3_r <= hour2_r;
      min1_r <= min_i;
      min2_r <= min1_r;
      min3_r <= min2_r;
      min4_r <= min3_r;
      sec1_r <= sec_i;
      sec2_r <= sec1_r;
      sec3_r <= sec2_r;
      sec4_r <= sec3_r;
      sec5_r <= sec4_r;
    end
  end

  assign res.vld = v_r[6];
  assign res.err = e_r[6];
  assign res.secs = t6_r[30:0];

endmodule

`default_nettype wire

[rtl/ute_decode.sv]
// six-stage pipe: seconds back to normalized calendar fields by constant reciprocals
// depends on ute_pkg
`default_nettype none

module ute_decode import ute_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     adv,
  input  enc_out_t enc,
  output dec_out_t res
);

  logic [6:1]  v_r, e_r;
  logic [30:0] t1_r, t2_r, t3_r, t4_r, t5_r;

  // stage 1: day number
  logic [48:0] dprod;
  logic [14:0] days1_r;

  // stage 2: second of day, cycle day, weekday base
  logic [16:0] rem2_r, rem3_r;
  logic [14:0] cd2_r, cd3_r;
  logic [14:0] wd2_r, wd3_r;

  // stage 3: quotients
  logic [33:0] hprod;
  logic [29:0] cprod;
  logic [30:0] wprod;
  logic [4:0]  hr3_r, hr4_r, hr5_r;
  logic [4:0]  q3_r, q4_r;
  logic [12:0] wk3_r;

  // stage 4: remainders
  logic [11:0] ms4_r, ms5_r;
  logic [10:0] r4_r;
  logic [2:0]  wd4_r, wd5_r;

  // stage 5: minute, year, day of year
  logic [24:0] mprod;
  logic [1:0]  yoff;
  logic [10:0] ybase;
  logic [5:0]  min5_r;
  logic [8:0]  yd5_r;
  logic [7:0]  ny5_r;
  logic        lp5_r;

  // stage 6: second, month, day of month
  logic [3:0]        nm;
  logic signed [9:0] mstart;
  logic [5:0]        sec6;
  logic [4:0]        mday6;

  // each quotient is taken from the previous stage so it lines up with its remainder
  assign dprod = 49'(enc.secs[30:7]) * 49'(RECIP_DIV675);
  assign hprod = 34'(rem2_r) * 34'(RECIP_DIV3600);
  assign cprod = 30'(cd2_r) * 30'(RECIP_DIV1461);
  assign wprod = 31'(wd2_r) * 31'(RECIP_DIV7);
  assign mprod = 25'(ms4_r) * 25'(RECIP_DIV60);

  always_comb begin
    yoff = 2'd0;
    ybase = 11'd0;
    if (r4_r >= 11'd1096) begin
      yoff = 2'd3;
      ybase = 11'd1096;
    end else if (r4_r >= 11'd731) begin
      yoff = 2'd2;
      ybase = 11'd731;
    end else if (r4_r >= 11'd366) begin
      yoff = 2'd1;
      ybase = 11'd366;
    end
  end

  // month starts rise, so the month is the count of starts already passed
  always_comb begin
    nm = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if ($signed({1'b0, yd5_r}) >= month_base(4'(k)) + 10'sd1
          + $signed({9'd0, (k > 1) && lp5_r})) begin
        nm = nm + 4'd1;
      end
    end
    mstart = month_base(nm) + 10'sd1 + $signed({9'd0, (nm > 4'd1) && lp5_r});
  end

  assign sec6 = 6'(ms5_r - 12'(min5_r) * 12'd60);
  assign mday6 = 5'($signed({1'b0, yd5_r}) - mstart + 10'sd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[5:1], enc.vld};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_r <= {e_r[5:1], enc.err};
      t1_r <= enc.secs;
      t2_r <= t1_r;
      t3_r <= t2_r;
      t4_r <= t3_r;
      t5_r <= t4_r;
      days1_r <= dprod[48:34];
      rem2_r <= 17'(t1_r - 31'(days1_r) * 31'd86400);
      cd2_r <= days1_r + 15'(EPOCH_CYCLE_OFS);
      wd2_r <= days1_r + 15'd4;
      rem3_r <= rem2_r;
      cd3_r <= cd2_r;
      wd3_r <= wd2_r;
      hr3_r <= hprod[32:28];
      q3_r <= cprod[29:25];
      wk3_r <= wprod[30:18];
      hr4_r <= hr3_r;
      hr5_r <= hr4_r;
      ms4_r <= 12'(rem3_r - 17'(hr3_r) * 17'd3600);
      r4_r <= 11'(cd3_r - 15'(q3_r) * 15'(DAYS_PER_CYCLE));
      wd4_r <= 3'(wd3_r - 15'(wk3_r) * 15'd7);
      q4_r <= q3_r;
      ms5_r <= ms4_r;
      wd5_r <= wd4_r;
      min5_r <= mprod[23:18];
      yd5_r <= 9'(r4_r - ybase);
      ny5_r <= 8'(CYCLE_BASE_YEAR) + {1'b0, q4_r, 2'b00} + 8'(yoff);
      lp5_r <= (yoff == 2'd0);
      if (e_r[5]) begin
        res.epoch_seconds <= '0;
        res.norm_year <= '0;
        res.norm_month <= '0;
        res.norm_mday <= '0;
        res.norm_hour <= '0;
        res.norm_minute <= '0;
        res.norm_second <= '0;
        res.week_day <= '0;
        res.year_day <= '0;
      end else begin
        res.epoch_seconds <= t5_r;
        res.norm_year <= ny5_r;
        res.norm_month <= nm;
        res.norm_mday <= mday6;
        res.norm_hour <= hr5_r;
        res.norm_minute <= min5_r;
        res.norm_second <= sec6;
        res.week_day <= wd5_r;
        res.year_day <= yd5_r;
      end
    end
  end

  assign res.vld = v_r[6];
  assign res.error_flag = e_r[6];

endmodule

`default_nettype wire

[rtl/utc_date_to_epoch_seconds.sv]
// top level: broken-down utc time to 32-bit unix seconds and back to calendar fields
// depends on ute_pkg, ute_if, ute_encode and ute_decode
`default_nettype none

// Converts one broken-down UTC time per beat (years since 1900, zero-based month, day,
// hour, minute, second, all signed 32-bit and possibly out of range) into seconds since
// 1970-01-01 and the normalized calendar fields, weekday and day of year. A beat is taken
// every cycle unless a finished result is held back at the output. The result beat comes
// out of the twelve-stage pipeline, whose first stage is loaded by the accepting edge:
// six stages in the encode pipe (month carry by a reciprocal multiply, day count, three
// checked multiply-add steps) and six in the decode pipe (reciprocal divisions by 86400,
// 3600, 1461, 7 and 60 with their remainders, then the month search). All stages advance
// together and stop while a finished result waits, so a stall drops or repeats nothing.
// A year outside 69..139, a 32-bit overflow at any step, or a time before 1970 gives
// error_flag set and every other field zero.

module utc_date_to_epoch_seconds import ute_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  ute_in_if.sink    in_if,
  ute_out_if.source out_if
);

  enc_out_t enc;
  dec_out_t dec;
  logic     adv;

  // the whole pipe moves unless the output beat is waiting
  assign adv = !dec.vld || out_if.ready;
  assign in_if.ready = adv;

  ute_encode u_encode (
    .clk    (clk),
    .rst_n  (rst_n),
    .adv    (adv),
    .in_vld (in_if.valid),
    .year_i (in_if.year_since_1900),
    .mon_i  (in_if.month_raw),
    .mday_i (in_if.day_of_month),
    .hour_i (in_if.hour_raw),
    .min_i  (in_if.minute_raw),
    .sec_i  (in_if.second_raw),
    .res    (enc)
  );

  ute_decode u_decode (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .enc   (enc),
    .res   (dec)
  );

  // result beat straight from the last stage register
  assign out_if.valid = dec.vld;
  assign out_if.epoch_seconds = dec.epoch_seconds;
  assign out_if.error_flag = dec.error_flag;
  assign out_if.norm_year = dec.norm_year;
  assign out_if.norm_month = dec.norm_month;
  assign out_if.norm_mday = dec.norm_mday;
  assign out_if.norm_hour = dec.norm_hour;
  assign out_if.norm_minute = dec.norm_minute;
  assign out_if.norm_second = dec.norm_second;
  assign out_if.week_day = dec.week_day;
  assign out_if.year_day = dec.year_day;

  // an error beat carries nothing but the flag
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.error_flag |->
      out_if.epoch_seconds == '0 && out_if.norm_year == '0 && out_if.norm_mday == '0)
    else $error("error beat with nonzero fields");

  // a good beat has its time of day in range
  a_tod_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.error_flag |->
      out_if.norm_hour <= 5'd23 && out_if.norm_minute <= 6'd59 &&
      out_if.norm_second <= 6'd59 && out_if.week_day <= 3'd6)
    else $error("time of day out of range");

  // a good beat has a real date inside the epoch window
  a_date_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && !out_if.error_flag |->
      out_if.norm_year >= 8'd70 && out_if.norm_year <= 8'd138 &&
      out_if.norm_month <= 4'd11 && out_if.norm_mday >= 5'd1 && out_if.year_day <= 9'd365)
    else $error("calendar date out of range");

  // input is held off exactly while a result beat is stalled
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready == (!out_if.valid || out_if.ready))
    else $error("input ready disagrees with output stall");

endmodule

`default_nettype wire
